/* src/open_addressing_hash_table_top_macros.svh */
// Assertion macros for the hash table checker
`ifndef OPEN_ADDRESSING_HASH_TABLE_TOP_MACROS_SVH
`define OPEN_ADDRESSING_HASH_TABLE_TOP_MACROS_SVH

// Implication checked on every clock edge outside reset
`define OAHT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define OAHT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/oaht_pkg.sv */
//------------------------------------------------------------------------------
// oaht_pkg
// Types and constants shared by the hash table modules.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

package oaht_pkg;

	// slot count: a power of two, at most 16 (hash reduction is a mask, rsp.slot is 4 bits)
	localparam int unsigned TABLE_SLOTS_DEF = 16;
	localparam int unsigned KEY_CHARS_DEF   = 8;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;

	localparam logic [1:0] ST_DONE      = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_USED  = 2'd1;
	localparam logic [1:0] SLOT_TOMB  = 2'd2;

	typedef struct packed {
		logic [1:0]  operation;
		logic [63:0] key_chars;
		logic [3:0]  key_length;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] result_value;
		logic [3:0]  slot;
	} rsp_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_NORM,
		S_HASH,
		S_READ,
		S_PROBE,
		S_RESP
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic norm_step;
		logic hash_step;
		logic probe_init;
		logic rd_issue;
		logic probe_next;
		logic commit;
		logic respond;
	} ctrl_t;

	// datapath -> controller
	typedef struct packed {
		logic norm_done;
		logic hash_done;
		logic probe_stop;
		logic probe_last;
	} stat_t;

endpackage

/* src/oaht_ctrl.sv */
//------------------------------------------------------------------------------
// oaht_ctrl
// Sequencer for normalise, hash and probe phases of one transaction.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module oaht_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  oaht_pkg::stat_t st,
	output oaht_pkg::ctrl_t ctl,
	output logic            busy
);

	oaht_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= oaht_pkg::S_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			oaht_pkg::S_IDLE:  if (start) state_d = oaht_pkg::S_NORM;
			oaht_pkg::S_NORM:  if (st.norm_done) state_d = oaht_pkg::S_HASH;
			oaht_pkg::S_HASH:  if (st.hash_done) state_d = oaht_pkg::S_READ;
			oaht_pkg::S_READ:  state_d = oaht_pkg::S_PROBE;
			oaht_pkg::S_PROBE: if (st.probe_stop || st.probe_last) state_d = oaht_pkg::S_RESP;
			                   else state_d = oaht_pkg::S_READ;
			oaht_pkg::S_RESP:  state_d = oaht_pkg::S_IDLE;
			default:           state_d = oaht_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		ctl  = '0;
		busy = 1'b1;
		unique case (state_q)
			oaht_pkg::S_IDLE: begin
				busy     = 1'b0;
				ctl.load = start;
			end
			oaht_pkg::S_NORM: ctl.norm_step = 1'b1;
			oaht_pkg::S_HASH: begin
				ctl.hash_step  = 1'b1;
				ctl.probe_init = st.hash_done;
			end
			oaht_pkg::S_READ: ctl.rd_issue = 1'b1;
			oaht_pkg::S_PROBE: begin
				ctl.commit     = st.probe_stop;
				ctl.probe_next = !(st.probe_stop || st.probe_last);
			end
			oaht_pkg::S_RESP: ctl.respond = 1'b1;
			default: busy = 1'b1;
		endcase
	end

endmodule

/* src/oaht_dpath.sv */
//------------------------------------------------------------------------------
// oaht_dpath
// Key normalisation, hash, slot store and probe datapath.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module oaht_dpath #(
	parameter int unsigned KEY_CHARS   = oaht_pkg::KEY_CHARS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  oaht_pkg::req_t  req,
	input  oaht_pkg::ctrl_t ctl,
	output oaht_pkg::stat_t st,
	output oaht_pkg::rsp_t  rsp,
	output logic            rsp_valid
);

	localparam int unsigned TABLE_SLOTS = oaht_pkg::TABLE_SLOTS_DEF;
	localparam int unsigned AW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
	localparam int unsigned KW = 8 * KEY_CHARS;
	localparam int unsigned LW = $clog2(KEY_CHARS + 1);
	localparam int unsigned CW = $clog2(TABLE_SLOTS + 1);
	localparam logic [LW-1:0] KMAX = LW'(KEY_CHARS);

	// request and key
	logic [1:0]    op_q;
	logic [63:0]   raw_q;
	logic [LW-1:0] lim_q;
	logic [31:0]   val_q;
	logic [KW-1:0] key_q;
	logic [LW-1:0] len_q;
	logic          stop_q;
	logic [LW-1:0] hidx_q;
	logic [AW-1:0] h_q;

	// probe
	logic [AW-1:0] t_q;
	logic [CW-1:0] cnt_q;
	logic [1:0]    stat_rd_q;
	logic [KW-1:0] key_rd_q;
	logic [LW-1:0] len_rd_q;
	logic [31:0]   val_rd_q;

	logic [1:0]    slot_status_q [TABLE_SLOTS];
	logic [KW-1:0] slot_key_q    [TABLE_SLOTS];
	logic [LW-1:0] slot_len_q    [TABLE_SLOTS];
	logic [31:0]   slot_val_q    [TABLE_SLOTS];

	logic [7:0]  nbyte, hbyte;
	logic [8:0]  hsum;
	logic [16:0] hprod;
	logic        hit, insert_ok;

	assign nbyte = raw_q[8*len_q[$clog2(KEY_CHARS > 1 ? KEY_CHARS : 2)-1:0] +: 8];
	assign hbyte = key_q[8*hidx_q[$clog2(KEY_CHARS > 1 ? KEY_CHARS : 2)-1:0] +: 8];
	assign hsum  = {1'b0, 8'(h_q)} + {1'b0, hbyte};
	assign hprod = 17'(hsum * hbyte);

	assign st.norm_done = stop_q || (len_q == lim_q) || (nbyte == 8'd0);
	assign st.hash_done = (hidx_q == len_q);
	assign hit       = (stat_rd_q == oaht_pkg::SLOT_USED) && (len_rd_q == len_q)
	                   && (key_rd_q == key_q);
	assign insert_ok = (stat_rd_q != oaht_pkg::SLOT_USED);
	always_comb begin
		unique case (op_q) inside
			oaht_pkg::OP_INSERT: st.probe_stop = insert_ok;
			oaht_pkg::OP_SEARCH, oaht_pkg::OP_DELETE:
				st.probe_stop = hit || (stat_rd_q == oaht_pkg::SLOT_EMPTY);
			default: st.probe_stop = 1'b1;
		endcase
	end
	assign st.probe_last = (cnt_q == CW'(TABLE_SLOTS - 1));

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			op_q   <= req.operation;
			raw_q  <= req.key_chars;
			lim_q  <= (req.key_length > 4'(KEY_CHARS)) ? KMAX : LW'(req.key_length);
			val_q  <= req.value;
			key_q  <= '0;
			len_q  <= '0;
			stop_q <= 1'b0;
			hidx_q <= '0;
			h_q    <= '0;
		end
		if (ctl.norm_step) begin
			if (st.norm_done) stop_q <= 1'b1;
			else begin
				key_q[8*len_q[$clog2(KEY_CHARS > 1 ? KEY_CHARS : 2)-1:0] +: 8] <= nbyte;
				len_q <= len_q + 1'b1;
			end
		end
		if (ctl.hash_step && !st.hash_done) begin
			h_q    <= hprod[AW-1:0];
			hidx_q <= hidx_q + 1'b1;
		end
		if (ctl.probe_init) begin
			t_q   <= h_q;
			cnt_q <= '0;
		end
		if (ctl.probe_next) begin
			t_q   <= (t_q == AW'(TABLE_SLOTS - 1)) ? '0 : t_q + 1'b1;
			cnt_q <= cnt_q + 1'b1;
		end
		if (ctl.rd_issue) begin
			key_rd_q <= slot_key_q[t_q];
			len_rd_q <= slot_len_q[t_q];
			val_rd_q <= slot_val_q[t_q];
		end
		if (ctl.commit && op_q == oaht_pkg::OP_INSERT) begin
			slot_key_q[t_q] <= key_q;
			slot_len_q[t_q] <= len_q;
			slot_val_q[t_q] <= val_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TABLE_SLOTS; i++) slot_status_q[i] <= oaht_pkg::SLOT_EMPTY;
			stat_rd_q <= oaht_pkg::SLOT_EMPTY;
			rsp_valid <= 1'b0;
			rsp       <= '0;
		end else begin
			rsp_valid <= 1'b0;
			if (ctl.rd_issue) stat_rd_q <= slot_status_q[t_q];
			if (ctl.load) begin
				rsp.status       <= oaht_pkg::ST_NOT_FOUND;
				rsp.result_value <= '0;
				rsp.slot         <= '0;
				if (req.operation == oaht_pkg::OP_INSERT) rsp.status <= oaht_pkg::ST_FULL;
			end
			if (ctl.commit) begin
				if (op_q == oaht_pkg::OP_INSERT) begin
					slot_status_q[t_q] <= oaht_pkg::SLOT_USED;
					rsp.status <= oaht_pkg::ST_DONE;
					rsp.slot   <= 4'(t_q);
				end else if ((op_q == oaht_pkg::OP_SEARCH || op_q == oaht_pkg::OP_DELETE) && hit) begin
					if (op_q == oaht_pkg::OP_DELETE) slot_status_q[t_q] <= oaht_pkg::SLOT_TOMB;
					rsp.status       <= oaht_pkg::ST_DONE;
					rsp.result_value <= val_rd_q;
					rsp.slot         <= 4'(t_q);
				end
			end
			if (ctl.respond) rsp_valid <= 1'b1;
		end
	end

endmodule

/* src/open_addressing_hash_table_top.sv */
//------------------------------------------------------------------------------
// open_addressing_hash_table_top
// Linear-probing hash table with tombstones, one transaction at a time.
//------------------------------------------------------------------------------
// A transaction is taken when start is high and busy low. It is latched, the
// key is trimmed and then hashed (one byte per step), and slots are probed in
// turn (registered slot read, then compare), up to TABLE_SLOTS slots, before
// the result is presented. The result sits on rsp for exactly one cycle with
// done high and cannot be held off; busy is already low in that cycle, so the
// next transaction may be taken with it.
// The slot count is the package constant TABLE_SLOTS_DEF.
`timescale 1ns / 1ps

module open_addressing_hash_table_top #(
	parameter int unsigned KEY_CHARS   = oaht_pkg::KEY_CHARS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  oaht_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output oaht_pkg::rsp_t rsp
);

	oaht_pkg::ctrl_t ctl;
	oaht_pkg::stat_t st;

	oaht_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .st(st), .ctl(ctl), .busy(busy)
	);

	oaht_dpath #(.KEY_CHARS(KEY_CHARS)) u_dpath (
		.clk(clk), .arst_n(arst_n), .req(req), .ctl(ctl), .st(st),
		.rsp(rsp), .rsp_valid(done)
	);

endmodule

/* src/oaht_checker.sv */
//------------------------------------------------------------------------------
// oaht_checker
// Port-level checks on the hash table, bound to the top level.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "open_addressing_hash_table_top_macros.svh"

module oaht_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input oaht_pkg::rsp_t rsp
);

	`OAHT_ASSERT_NXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy not raised after accept")
	`OAHT_ASSERT_IMP(a_done_idle, clk, arst_n, done, !busy, "result while still busy")
	`OAHT_ASSERT_NXT(a_done_single, clk, arst_n, done, !done, "result not single cycle")
	`OAHT_ASSERT_IMP(a_fail_zero, clk, arst_n, done && rsp.status != oaht_pkg::ST_DONE, rsp.result_value == 32'd0 && rsp.slot == 4'd0, "failed result not zero")

endmodule

bind open_addressing_hash_table_top oaht_checker u_oaht_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done), .rsp(rsp)
);

/* verif/tb_top.sv */
//------------------------------------------------------------------------------
// tb_top
// Self-checking bench for the linear-probing hash table. Requests go in by
// start/busy; each response is compared against a behavioural table model
// kept in the bench. A directed table opens the run, random phases follow.
//------------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int unsigned SLOTS = oaht_pkg::TABLE_SLOTS_DEF;
	localparam int unsigned KMAX  = oaht_pkg::KEY_CHARS_DEF;
	localparam int unsigned N_RAND = 500;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct {
		oaht_pkg::req_t rq;
		logic           chk;
		oaht_pkg::rsp_t rs;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	oaht_pkg::req_t req = '0;
	logic busy, done;
	oaht_pkg::rsp_t rsp;

	logic [1:0]  tbl_state [SLOTS];
	logic [63:0] tbl_key   [SLOTS];
	logic [3:0]  tbl_len   [SLOTS];
	logic [31:0] tbl_val   [SLOTS];

	oaht_pkg::rsp_t rsp_pending [$];
	logic [63:0] key_pool [8];
	int mismatches = 0;
	int responses = 0;
	int sent = 0;
	int idle_pct = 0;

	open_addressing_hash_table_top i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req),
		.busy(busy), .done(done), .rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic oaht_pkg::rsp_t table_apply(oaht_pkg::req_t r);
		oaht_pkg::rsp_t o;
		logic [63:0] k;
		int unsigned n, lim, h, t, c;
		bit stop;
		k = '0; n = 0; h = 0; stop = 0;
		lim = (r.key_length > KMAX) ? KMAX : r.key_length;
		for (int i = 0; i < KMAX; i++) begin
			if (!stop && i < lim && r.key_chars[8*i +: 8] != 8'd0) begin
				k[8*i +: 8] = r.key_chars[8*i +: 8];
				n++;
			end else begin
				stop = 1;
			end
		end
		for (int i = 0; i < n; i++) begin
			c = k[8*i +: 8];
			h = ((h + c) * c) % SLOTS;
		end
		o = '{status: oaht_pkg::ST_NOT_FOUND, result_value: '0, slot: '0};
		stop = 0;
		if (r.operation == oaht_pkg::OP_INSERT) begin
			o.status = oaht_pkg::ST_FULL;
			for (int i = 0; i < SLOTS; i++) begin
				t = (h + i) % SLOTS;
				if (!stop && tbl_state[t] != oaht_pkg::SLOT_USED) begin
					tbl_state[t] = oaht_pkg::SLOT_USED;
					tbl_key[t] = k;
					tbl_len[t] = n[3:0];
					tbl_val[t] = r.value;
					o.status = oaht_pkg::ST_DONE;
					o.slot = t[3:0];
					stop = 1;
				end
			end
		end else if (r.operation == oaht_pkg::OP_SEARCH || r.operation == oaht_pkg::OP_DELETE) begin
			for (int i = 0; i < SLOTS; i++) begin
				t = (h + i) % SLOTS;
				if (!stop) begin
					if (tbl_state[t] == oaht_pkg::SLOT_EMPTY) begin
						stop = 1;
					end else if (tbl_state[t] == oaht_pkg::SLOT_USED && tbl_len[t] == n[3:0]
							&& tbl_key[t] == k) begin
						o.status = oaht_pkg::ST_DONE;
						o.result_value = tbl_val[t];
						o.slot = t[3:0];
						if (r.operation == oaht_pkg::OP_DELETE)
							tbl_state[t] = oaht_pkg::SLOT_TOMB;
						stop = 1;
					end
				end
			end
		end
		return o;
	endfunction

	task automatic send_request(oaht_pkg::req_t r, logic chk, oaht_pkg::rsp_t fixed);
		oaht_pkg::rsp_t e;
		while ($urandom_range(99) < idle_pct) @(negedge clk);
		while (busy) @(negedge clk);
		e = table_apply(r);
		if (chk && e != fixed) begin
			mismatches++;
			if (mismatches <= 10)
				$display("table row disagrees: fixed %h model %h", fixed, e);
		end
		rsp_pending.push_back(e);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		sent++;
		@(negedge clk);
		start <= 1'b0;
	endtask

	function automatic oaht_pkg::req_t random_request();
		oaht_pkg::req_t r;
		int unsigned sel;
		r.operation = 2'($urandom_range(2));
		sel = $urandom_range(99);
		if (sel < 80) begin
			r.key_chars = key_pool[$urandom_range(7)];
			r.key_length = 4'($urandom_range(1, 8));
			if ($urandom_range(3) == 0) r.key_length = 4'd8;
		end else begin
			r.key_chars = {$urandom, $urandom};
			if (sel < 85) r.operation = OP_UNUSED;
			r.key_length = 4'($urandom_range(15));
		end
		if (sel >= 90) r.key_chars[8*$urandom_range(7) +: 8] = 8'd0;
		r.value = $urandom;
		return r;
	endfunction

	always @(posedge clk) begin
		if (done) begin
			responses++;
			if (rsp_pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected response %h", rsp);
			end else begin
				oaht_pkg::rsp_t e;
				e = rsp_pending.pop_front();
				if (rsp.status !== e.status || rsp.result_value !== e.result_value
						|| rsp.slot !== e.slot) begin
					mismatches++;
					if (mismatches <= 10)
						$display("response mismatch: exp %0d/%h/%0d got %0d/%h/%0d",
							e.status, e.result_value, e.slot,
							rsp.status, rsp.result_value, rsp.slot);
				end
			end
		end
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		dir_row_t dir [$];
		oaht_pkg::rsp_t none;
		none = '{status: oaht_pkg::ST_NOT_FOUND, result_value: '0, slot: '0};
		for (int i = 0; i < SLOTS; i++) begin
			tbl_state[i] = oaht_pkg::SLOT_EMPTY;
			tbl_key[i] = '0; tbl_len[i] = '0; tbl_val[i] = '0;
		end
		for (int i = 0; i < 8; i++) key_pool[i] = {$urandom, $urandom} | 64'h0101010101010101;
		// after reset: empty search, empty key at slot 0 (insert, search, delete twice), unused op, trimmed keys
		dir.push_back('{'{oaht_pkg::OP_SEARCH, 64'h41, 4'd1, 32'h0}, 1, none});
		dir.push_back('{'{oaht_pkg::OP_INSERT, 64'h0, 4'd0, 32'hFFFFFFFF}, 1,
			'{oaht_pkg::ST_DONE, 32'h0, 4'd0}});
		dir.push_back('{'{oaht_pkg::OP_SEARCH, 64'hFFFF, 4'd0, 32'h0}, 1,
			'{oaht_pkg::ST_DONE, 32'hFFFFFFFF, 4'd0}});
		dir.push_back('{'{OP_UNUSED, 64'hFFFFFFFFFFFFFFFF, 4'd15, 32'hFFFFFFFF}, 1, none});
		dir.push_back('{'{oaht_pkg::OP_INSERT, 64'hFFFFFFFFFFFFFFFF, 4'd15, 32'h12345678},
			0, none});
		dir.push_back('{'{oaht_pkg::OP_SEARCH, 64'hFFFFFFFFFFFFFFFF, 4'd8, 32'h0}, 0, none});
		dir.push_back('{'{oaht_pkg::OP_INSERT, 64'h0000_0000_0000_0080, 4'd8, 32'h1},
			0, none});
		dir.push_back('{'{oaht_pkg::OP_SEARCH, 64'hAA00_0000_0000_0080, 4'd8, 32'h0},
			0, none});
		dir.push_back('{'{oaht_pkg::OP_DELETE, 64'h0, 4'd0, 32'h0}, 1,
			'{oaht_pkg::ST_DONE, 32'hFFFFFFFF, 4'd0}});
		dir.push_back('{'{oaht_pkg::OP_DELETE, 64'h0, 4'd0, 32'h0}, 1, none});
		// fill the table, then probe it full
		for (int i = 0; i < 16; i++)
			dir.push_back('{'{oaht_pkg::OP_INSERT, 64'h01 + i, 4'd1, 32'h100 + i}, 0, none});
		dir.push_back('{'{oaht_pkg::OP_INSERT, 64'h7F, 4'd1, 32'h0}, 1,
			'{oaht_pkg::ST_FULL, 32'h0, 4'd0}});
		dir.push_back('{'{oaht_pkg::OP_SEARCH, 64'h7F, 4'd1, 32'h0}, 1, none});
		dir.push_back('{'{oaht_pkg::OP_DELETE, 64'h7F, 4'd1, 32'h0}, 1, none});

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		foreach (dir[i]) send_request(dir[i].rq, dir[i].chk, dir[i].rs);
		// clear the table down for the random part
		for (int i = 0; i < 16; i++)
			send_request('{oaht_pkg::OP_DELETE, 64'h01 + i, 4'd1, 32'h0}, 0, none);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 0) ? 0 : (ph == 3 ? 33 : 65);
			for (int i = 0; i < N_RAND / 4; i++)
				send_request(random_request(), 0, none);
		end
		while (rsp_pending.size() != 0) @(posedge clk);
		repeat (2 * KMAX + 2 * SLOTS + 10) @(posedge clk);
		$display("%0d requests sent, %0d responses checked; inserts, searches, deletes,",
			sent, responses);
		$display("full table, tombstones, trimmed and unused-op requests exercised");
		if (mismatches == 0 && rsp_pending.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* sim.f */
+incdir+src
src/oaht_pkg.sv
src/oaht_ctrl.sv
src/oaht_dpath.sv
src/open_addressing_hash_table_top.sv
src/oaht_checker.sv
verif/tb_top.sv
